FILE: src/tlgs_pkg.sv
`default_nettype none

package tlgs_pkg;

   // Field widths fixed by the interface
   localparam int ADDR_WIDTH = 6;
   localparam int CMD_WIDTH  = 2;

   typedef logic [CMD_WIDTH-1:0] cmd_type;

   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_STEP  = 2'd2;

   // Eight neighbors sum to at most 8
   typedef logic [3:0] nbr_count_type;

   localparam nbr_count_type SURVIVE_COUNT = 4'd2;
   localparam nbr_count_type BIRTH_COUNT   = 4'd3;

   // Load controls for one row cell
   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: src/tlgs_row_cell.sv
`default_nettype none

module tlgs_row_cell
   import tlgs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctl_type     ctl,
   input  wire logic [WIDTH-1:0] shift_row,
   input  wire logic [WIDTH-1:0] write_row,
   output logic      [WIDTH-1:0] row_out
);

   logic [WIDTH-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (ctl.shift) begin
         row_ff <= shift_row;
      end else if (ctl.write) begin
         row_ff <= write_row;
      end
   end

   assign row_out = row_ff;

endmodule

`default_nettype wire

FILE: src/tlgs_next_row.sv
`default_nettype none

module tlgs_next_row
   import tlgs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0] up_row,
   input  wire logic [WIDTH-1:0] mid_row,
   input  wire logic [WIDTH-1:0] dn_row,
   output logic      [WIDTH-1:0] next_row
);

   nbr_count_type cnt [WIDTH];

   genvar c;
   generate
      for (c = 0; c < WIDTH; c++) begin : g_col
         localparam int LF = (c + WIDTH - 1) % WIDTH;
         localparam int RT = (c + 1) % WIDTH;

         assign cnt[c] = nbr_count_type'(up_row[LF]) + nbr_count_type'(up_row[c])
                       + nbr_count_type'(up_row[RT]) + nbr_count_type'(mid_row[LF])
                       + nbr_count_type'(mid_row[RT]) + nbr_count_type'(dn_row[LF])
                       + nbr_count_type'(dn_row[c]) + nbr_count_type'(dn_row[RT]);

         assign next_row[c] = (cnt[c] == BIRTH_COUNT)
                            || (mid_row[c] && (cnt[c] == SURVIVE_COUNT));
      end
   endgenerate

endmodule

`default_nettype wire

FILE: src/toroidal_life_generation_step_core.sv
`default_nettype none

// Toroidal Life grid engine, GRID_HEIGHT rows by GRID_WIDTH one-bit cells.
// Input channel req_*: command (write cell, read cell, step generation), row,
// column, alive_in. Row and column wrap modulo the grid size.
// Result channel rsp_*: one word per request; rsp_cell_alive is the cell for a
// read and 0 otherwise.
// The rows sit in a ring of row cells that rotates one row per cycle. A read
// or write rotates the ring until the addressed row reaches the head cell,
// then acts on it. A step rotates the ring once around while computing each
// new row from the head and its two wrapped neighbors. One request is in
// work at a time; req_ready rises again as soon as the result is registered,
// so the next request is taken while the response still waits.
// Reset clears every cell (all dead) and the control state.
// If the receiver stalls, the response is held in the output register and a
// following request completes its work but waits to post its result.
module toroidal_life_generation_step_core
   import tlgs_pkg::*;
#(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_WIDTH-1:0]  req_command,
   input  wire logic [ADDR_WIDTH-1:0] req_row,
   input  wire logic [ADDR_WIDTH-1:0] req_column,
   input  wire logic                  req_alive_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_cell_alive
);

   localparam int RW   = $clog2(GRID_HEIGHT);
   localparam int CW   = $clog2(GRID_WIDTH);
   localparam int NLUT = 2 ** ADDR_WIDTH;
   localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SEEK, ST_STEP, ST_POST} state_type;

   state_type        state_ff;
   cmd_type          cmd_ff;
   logic [RW-1:0]    row_ff;
   logic [CW-1:0]    col_ff;
   logic             alive_ff;
   logic [RW-1:0]    head_ff;
   logic [RW-1:0]    cnt_ff;
   logic             result_ff;
   logic [GRID_WIDTH-1:0] prev_ff;
   logic [GRID_WIDTH-1:0] first_ff;
   logic             rsp_valid_ff;
   logic             rsp_alive_ff;

   logic [RW-1:0]    row_lut [NLUT];
   logic [CW-1:0]    col_lut [NLUT];
   logic [GRID_WIDTH-1:0] rows [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] up_row, dn_row, new_row, tail_row, wr_row;
   logic             at_target, slot_free;
   cell_ctl_type     ctl, head_ctl;

   // Modulo tables for the 6-bit address fields
   genvar g;
   generate
      for (g = 0; g < NLUT; g++) begin : g_lut
         assign row_lut[g] = RW'(g % GRID_HEIGHT);
         assign col_lut[g] = CW'(g % GRID_WIDTH);
      end
   endgenerate

   assign at_target = (head_ff == row_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign ctl.shift = ((state_ff == ST_SEEK) && !at_target) || (state_ff == ST_STEP);
   assign ctl.write = 1'b0;
   assign head_ctl.shift = ctl.shift;
   assign head_ctl.write = (state_ff == ST_SEEK) && at_target && (cmd_ff == CMD_WRITE);

   // Old neighbors: the row above the first one is still untouched at the tail;
   // after that the previous head is kept in prev_ff, and the first row's old
   // value closes the torus on the last cycle.
   assign up_row = (cnt_ff == '0) ? rows[GRID_HEIGHT-1] : prev_ff;
   assign dn_row = (cnt_ff == LAST_ROW) ? first_ff : rows[1];

   tlgs_next_row #(
      .WIDTH (GRID_WIDTH)
   ) u_next_row (
      .up_row   (up_row),
      .mid_row  (rows[0]),
      .dn_row   (dn_row),
      .next_row (new_row)
   );

   assign tail_row = (state_ff == ST_STEP) ? new_row : rows[0];

   always_comb begin
      wr_row         = rows[0];
      wr_row[col_ff] = alive_ff;
   end

   generate
      for (g = 0; g < GRID_HEIGHT; g++) begin : g_cell
         if (g == 0) begin : g_head
            tlgs_row_cell #(
               .WIDTH (GRID_WIDTH)
            ) u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctl       (head_ctl),
               .shift_row (rows[1]),
               .write_row (wr_row),
               .row_out   (rows[0])
            );
         end else if (g == GRID_HEIGHT - 1) begin : g_tail
            tlgs_row_cell #(
               .WIDTH (GRID_WIDTH)
            ) u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctl       (ctl),
               .shift_row (tail_row),
               .write_row (tail_row),
               .row_out   (rows[g])
            );
         end else begin : g_mid
            tlgs_row_cell #(
               .WIDTH (GRID_WIDTH)
            ) u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctl       (ctl),
               .shift_row (rows[g+1]),
               .write_row (rows[g+1]),
               .row_out   (rows[g])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  case (req_command)
                     CMD_WRITE, CMD_READ: state_ff <= ST_SEEK;
                     CMD_STEP:            state_ff <= ST_STEP;
                     default:             state_ff <= ST_POST;
                  endcase
               end
            end
            ST_SEEK: begin
               if (at_target) begin
                  state_ff <= ST_POST;
               end else begin
                  head_ff <= (head_ff == LAST_ROW) ? '0 : head_ff + 1'b1;
               end
            end
            ST_STEP: begin
               // full turn of the ring: head index ends where it began
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_ROW) begin
                  state_ff <= ST_POST;
               end
            end
            ST_POST: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         cmd_ff    <= req_command;
         row_ff    <= row_lut[req_row];
         col_ff    <= col_lut[req_column];
         alive_ff  <= req_alive_in;
         result_ff <= 1'b0;
      end
      if ((state_ff == ST_SEEK) && at_target && (cmd_ff == CMD_READ)) begin
         result_ff <= rows[0][col_ff];
      end
      if (state_ff == ST_STEP) begin
         prev_ff <= rows[0];
         if (cnt_ff == '0) begin
            first_ff <= rows[0];
         end
      end
      if ((state_ff == ST_POST) && slot_free) begin
         rsp_alive_ff <= result_ff;
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_alive = rsp_alive_ff;

endmodule

`default_nettype wire

FILE: verif/life_grid_checker.sv
module life_grid_checker
   import tlgs_pkg::*;
#(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CMD_WIDTH-1:0]  req_command,
   input  logic [ADDR_WIDTH-1:0] req_row,
   input  logic [ADDR_WIDTH-1:0] req_column,
   input  logic                  req_alive_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_cell_alive,
   output int                    mismatch_count,
   output int                    owed_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // bit c of live_rows[r] is the cell at row r, column c
   logic [GRID_WIDTH-1:0] live_rows [GRID_HEIGHT];
   logic                  due_cells [$];
   int                    errors = 0;
   int                    word_index = 0;

   assign mismatch_count = errors;

   function automatic void advance_generation();
      logic [GRID_WIDTH-1:0] fresh [GRID_HEIGHT];
      int                    up, dn, lf, rt;
      nbr_count_type         n;
      logic                  live;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         up = (r + GRID_HEIGHT - 1) % GRID_HEIGHT;
         dn = (r + 1) % GRID_HEIGHT;
         for (int c = 0; c < GRID_WIDTH; c++) begin
            lf = (c + GRID_WIDTH - 1) % GRID_WIDTH;
            rt = (c + 1) % GRID_WIDTH;
            n = '0;
            n += live_rows[up][lf];
            n += live_rows[up][c];
            n += live_rows[up][rt];
            n += live_rows[r][lf];
            n += live_rows[r][rt];
            n += live_rows[dn][lf];
            n += live_rows[dn][c];
            n += live_rows[dn][rt];
            live = live_rows[r][c];
            fresh[r][c] = live ? (n == SURVIVE_COUNT || n == BIRTH_COUNT)
                               : (n == BIRTH_COUNT);
         end
      end
      // whole generation from the old grid, then swap in
      live_rows = fresh;
   endfunction

   function automatic logic apply_word(cmd_type cmd, logic [ADDR_WIDTH-1:0] row,
                                       logic [ADDR_WIDTH-1:0] col, logic alive);
      int   r, c;
      logic cell_out;
      r = row % GRID_HEIGHT;
      c = col % GRID_WIDTH;
      cell_out = 1'b0;
      case (cmd)
         CMD_WRITE: live_rows[r][c] = alive;
         CMD_READ:  cell_out = live_rows[r][c];
         CMD_STEP:  advance_generation();
         default:   ;
      endcase
      return cell_out;
   endfunction

   function automatic void flag_word(string what, logic want, logic got);
      if (errors < 10)
         $display("rsp word %0d: %s, expected %0b, got %0b", word_index, what, want, got);
      errors++;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         foreach (live_rows[r]) live_rows[r] = '0;
         due_cells.delete();
      end else begin
         // response first: a request accepted now cannot answer in the same cycle
         if (rsp_valid && rsp_ready) begin
            if (due_cells.size() == 0) begin
               flag_word("no word outstanding", 1'b0, rsp_cell_alive);
            end else begin
               want = due_cells.pop_front();
               if (rsp_cell_alive !== want)
                  flag_word("cell_alive mismatch", want, rsp_cell_alive);
            end
            word_index++;
         end
         if (req_valid && req_ready)
            due_cells.push_back(apply_word(req_command, req_row, req_column, req_alive_in));
      end
      owed_words <= due_cells.size();
   end

endmodule

FILE: verif/toroidal_life_generation_step_core_test.sv
module toroidal_life_generation_step_core_test
   import tlgs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          GRID_SIZE    = 64;
   localparam int          RUN_LIMIT    = 1_000_000;
   localparam int          LONG_HOLD    = 400;
   localparam int          DRAIN_CYCLES = 2 * GRID_SIZE + 32;
   localparam cmd_type     CMD_UNUSED   = 2'd3;
   localparam logic [5:0]  EDGE_ADDR    = 6'd63;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_WIDTH-1:0]  req_command = CMD_WRITE;
   logic [ADDR_WIDTH-1:0] req_row = '0;
   logic [ADDR_WIDTH-1:0] req_column = '0;
   logic                  req_alive_in = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_cell_alive;

   int mismatch_count;
   int owed_words;
   int cycle_count = 0;
   int sent_words = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;

   always #10 clock = ~clock;

   toroidal_life_generation_step_core #(
      .GRID_WIDTH (GRID_SIZE),
      .GRID_HEIGHT(GRID_SIZE)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_row       (req_row),
      .req_column    (req_column),
      .req_alive_in  (req_alive_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_alive(rsp_cell_alive)
   );

   life_grid_checker #(
      .GRID_WIDTH (GRID_SIZE),
      .GRID_HEIGHT(GRID_SIZE)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_row       (req_row),
      .req_column    (req_column),
      .req_alive_in  (req_alive_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_alive(rsp_cell_alive),
      .mismatch_count(mismatch_count),
      .owed_words    (owed_words)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("toroidal_life_generation_step_core_test NOT OK");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_word(input cmd_type cmd, input logic [5:0] row,
                            input logic [5:0] col, input logic alive);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_row      <= row;
      req_column   <= col;
      req_alive_in <= alive;
      do @(posedge clock); while (!req_ready);
      if (cmd != CMD_UNUSED)
         sent_words++;
   endtask

   function automatic logic [5:0] near_edge_or_any();
      if ($urandom_range(0, 3) == 0)
         return 6'(62 + $urandom_range(0, 3));
      return 6'($urandom_range(0, 63));
   endfunction

   // seed a small patch (often across the wrap), evolve it and probe around it
   task automatic seed_and_evolve();
      logic [5:0] base_r, base_c;
      int         span, n_cells, n_gens, n_reads;
      base_r  = near_edge_or_any();
      base_c  = near_edge_or_any();
      span    = $urandom_range(3, 7);
      n_cells = $urandom_range(span, span * span / 2 + 2);
      for (int i = 0; i < n_cells; i++)
         send_word(CMD_WRITE, base_r + 6'($urandom_range(0, span - 1)),
                   base_c + 6'($urandom_range(0, span - 1)),
                   $urandom_range(0, 99) < 65);
      n_gens = $urandom_range(1, 4);
      for (int g = 0; g < n_gens; g++) begin
         send_word(CMD_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1)));
         n_reads = $urandom_range(1, 4);
         for (int i = 0; i < n_reads; i++)
            send_word(CMD_READ, base_r + 6'($urandom_range(0, span + 1)) - 6'd1,
                      base_c + 6'($urandom_range(0, span + 1)) - 6'd1,
                      1'($urandom_range(0, 1)));
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         send_word(cmd_type'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
   endtask

   task automatic run_phase(input int words, input int send_pct, input int recv_pct,
                            input bit long_hold);
      int start;
      start          = sent_words;
      send_idle_pct  = send_pct;
      recv_stall_pct <= recv_pct;
      if (long_hold)
         hold_asked <= hold_asked + 1;
      while (sent_words - start < words) begin
         if ($urandom_range(0, 9) < 7)
            seed_and_evolve();
         else
            send_noise();
      end
   endtask

   initial begin
      send_idle_pct  = 15;
      recv_stall_pct = 52;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2 block spread over the four corners of the torus: stable
      send_word(CMD_WRITE, 6'd0, 6'd0, 1'b1);
      send_word(CMD_WRITE, 6'd0, EDGE_ADDR, 1'b1);
      send_word(CMD_WRITE, EDGE_ADDR, 6'd0, 1'b1);
      send_word(CMD_WRITE, EDGE_ADDR, EDGE_ADDR, 1'b1);
      send_word(CMD_READ, EDGE_ADDR, EDGE_ADDR, 1'b0);
      send_word(CMD_STEP, EDGE_ADDR, EDGE_ADDR, 1'b1);
      send_word(CMD_READ, 6'd0, 6'd0, 1'b1);
      send_word(CMD_READ, 6'd1, 6'd1, 1'b0);
      // unused command leaves the grid alone
      send_word(CMD_UNUSED, EDGE_ADDR, EDGE_ADDR, 1'b0);
      send_word(CMD_READ, EDGE_ADDR, 6'd0, 1'b0);
      // drop one corner: three neighbors bring it back
      send_word(CMD_WRITE, EDGE_ADDR, EDGE_ADDR, 1'b0);
      send_word(CMD_READ, EDGE_ADDR, EDGE_ADDR, 1'b1);
      send_word(CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_word(CMD_READ, EDGE_ADDR, EDGE_ADDR, 1'b0);
      // blinker in the middle
      send_word(CMD_WRITE, 6'd31, 6'd30, 1'b1);
      send_word(CMD_WRITE, 6'd31, 6'd31, 1'b1);
      send_word(CMD_WRITE, 6'd31, 6'd32, 1'b1);
      send_word(CMD_STEP, 6'd42, 6'd21, 1'b1);
      send_word(CMD_READ, 6'd30, 6'd31, 1'b0);
      send_word(CMD_READ, 6'd31, 6'd30, 1'b1);
      send_word(CMD_WRITE, 6'd5, 6'd5, 1'b0);
      send_word(CMD_UNUSED, 6'd0, 6'd0, 1'b0);
      send_word(CMD_STEP, 6'd21, 6'd42, 1'b0);
      send_word(CMD_READ, 6'd31, 6'd32, 1'b0);

      run_phase(530, 15, 52, 1'b1);
      run_phase(530, 52, 15, 1'b0);
      run_phase(540, 0, 0, 1'b1);
      req_valid <= 1'b0;

      do @(posedge clock); while (owed_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("toroidal_life_generation_step_core_test OK");
      else
         $display("toroidal_life_generation_step_core_test NOT OK");
      $finish;
   end

endmodule
